[rtl/sspe_pkg.sv]
// Shared constants, codes and beat types for the step sequencer pattern engine.
package sspe_pkg;

    // Geometry of the pattern store and the playlist
    localparam int TRACK_COUNT   = 8;
    localparam int STEP_COUNT    = 16;
    localparam int PATTERN_COUNT = 16;
    localparam int SONG_SLOTS    = 16;

    // Fixed field widths of the beats
    localparam int FIELD_W = 4;
    localparam int TRIG_W  = 8;
    localparam int LEN_W   = 5;
    localparam int CFG_IW  = 4;

    // Width used for range compares; holds every count above plus one
    localparam int CMP_W = 7;

    localparam int TRK_IW  = (TRACK_COUNT > 1) ? $clog2(TRACK_COUNT) : 1;
    localparam int STEP_IW = $clog2(STEP_COUNT);
    localparam int PAT_IW  = (PATTERN_COUNT > 1) ? $clog2(PATTERN_COUNT) : 1;
    localparam int SLOT_IW = (SONG_SLOTS > 1) ? $clog2(SONG_SLOTS) : 1;

    // Tracks that can show up in the trigger mask
    localparam int TRIG_TRACKS = (TRACK_COUNT < TRIG_W) ? TRACK_COUNT : TRIG_W;

    // Command codes
    localparam logic [FIELD_W-1:0] FN_TICK   = 4'd0;
    localparam logic [FIELD_W-1:0] FN_PLAY   = 4'd1;
    localparam logic [FIELD_W-1:0] FN_STOP   = 4'd2;
    localparam logic [FIELD_W-1:0] FN_NEXT   = 4'd3;
    localparam logic [FIELD_W-1:0] FN_PREV   = 4'd4;
    localparam logic [FIELD_W-1:0] FN_TOGGLE = 4'd5;
    localparam logic [FIELD_W-1:0] FN_CLEAR  = 4'd6;
    localparam logic [FIELD_W-1:0] FN_UNDO   = 4'd7;
    localparam logic [FIELD_W-1:0] FN_LIST   = 4'd8;

    // Configuration register indexes
    localparam logic [CFG_IW-1:0] CFG_PLAY_MODE   = 4'd0;
    localparam logic [CFG_IW-1:0] CFG_SONG_LENGTH = 4'd1;

    typedef logic [TRACK_COUNT-1:0][STEP_COUNT-1:0] t_pattern;

    typedef struct packed {
        logic [FIELD_W-1:0] func;
        logic [FIELD_W-1:0] track;
        logic [FIELD_W-1:0] step;
        logic [FIELD_W-1:0] slot;
        logic [FIELD_W-1:0] slot_pattern;
    } t_in_item;

    typedef struct packed {
        logic [TRIG_W-1:0]  triggers;
        logic               wrapped;
        logic [FIELD_W-1:0] position;
        logic [FIELD_W-1:0] playing_pattern;
        logic [FIELD_W-1:0] view_pattern;
        logic               running;
    } t_out_item;

    // Status fields of a result, everything except the trigger mask
    typedef struct packed {
        logic               wrapped;
        logic [FIELD_W-1:0] position;
        logic [FIELD_W-1:0] playing_pattern;
        logic [FIELD_W-1:0] view_pattern;
        logic               running;
    } t_status;

    typedef struct packed {
        logic              we;
        logic [CFG_IW-1:0] index;
        logic [LEN_W-1:0]  data;
    } t_cfg_wr;

    // Request from the sequencer to the pattern store for one beat
    typedef struct packed {
        logic               tick;
        logic               toggle;
        logic               clear;
        logic               undo;
        logic [PAT_IW-1:0]  sel;
        logic [TRK_IW-1:0]  trk;
        logic [STEP_IW-1:0] stp;
        logic [STEP_IW-1:0] pos;
    } t_store_req;

endpackage

[rtl/step_sequencer_pattern_engine.sv]
// Top level of the step sequencer pattern engine: beat registers and core wiring.
//
// Drum step sequencer engine. Each input beat is one command (tick, play, stop,
// next/prev pattern, toggle cell, clear, undo, playlist write) and yields exactly
// one result beat with the trigger mask and the transport status after the
// command. A beat is taken into an input register, decoded and applied to the
// pattern store and sequencer state once the output register can take its
// result, which is held there until the consumer takes it. The result passes
// two register stages; one beat per cycle is sustained while the output is not
// stalled, set by the single read-modify-write of the pattern store
// that each beat performs. The pattern store comes out of reset cleared through
// per-pattern valid bits, so no clearing pass is needed and beats are taken right
// after reset. Configuration (play mode, song length) is written through its own
// port, always ready, and should only be written while no beat is in flight.
module step_sequencer_pattern_engine (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // command beats
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  sspe_pkg::t_in_item            i_in_data,
    // result beats
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output sspe_pkg::t_out_item           o_out_data,
    // configuration writes
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [sspe_pkg::CFG_IW-1:0]   i_cfg_index,
    input  logic [sspe_pkg::LEN_W-1:0]    i_cfg_data
);

    // Input register: holds the beat until it executes
    logic                 r_in_vld;
    sspe_pkg::t_in_item   r_in;
    // Output register: holds the finished result until taken
    logic                 r_out_vld;
    sspe_pkg::t_out_item  r_out;

    logic                          fire;      // execute the held beat this cycle
    logic                          in_take;
    sspe_pkg::t_cfg_wr             cfg_wr;
    sspe_pkg::t_store_req          store_req;
    sspe_pkg::t_status             status;
    logic [sspe_pkg::TRIG_W-1:0]   triggers;

    // The held beat executes when the output register is free or being drained
    assign fire       = r_in_vld & (~r_out_vld | ~i_out_stall);
    assign o_in_stall = r_in_vld & ~fire;
    assign in_take    = i_in_valid & ~o_in_stall;

    assign o_cfg_ready = 1'b1;
    always_comb begin
        cfg_wr.we    = i_cfg_valid & o_cfg_ready;
        cfg_wr.index = i_cfg_index;
        cfg_wr.data  = i_cfg_data;
    end

    sspe_sequencer u_seq (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_fire   (fire),
        .i_item   (r_in),
        .i_cfg    (cfg_wr),
        .o_req    (store_req),
        .o_status (status)
    );

    sspe_pattern_store u_store (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_req      (store_req),
        .o_triggers (triggers)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld  <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            if (in_take) begin
                r_in_vld <= 1'b1;
            end else if (fire) begin
                r_in_vld <= 1'b0;
            end
            if (fire) begin
                r_out_vld <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    // payload registers, no reset
    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_in <= i_in_data;
        end
        if (fire) begin
            r_out.triggers        <= triggers;
            r_out.wrapped         <= status.wrapped;
            r_out.position        <= status.position;
            r_out.playing_pattern <= status.playing_pattern;
            r_out.view_pattern    <= status.view_pattern;
            r_out.running         <= status.running;
        end
    end

    assign o_out_valid = r_out_vld;
    assign o_out_data  = r_out;

endmodule

[rtl/sspe_pattern_store.sv]
// Pattern store with per-entry valid bits, undo buffer and trigger column read.
module sspe_pattern_store (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  sspe_pkg::t_store_req          i_req,
    output logic [sspe_pkg::TRIG_W-1:0]   o_triggers
);

    sspe_pkg::t_pattern                       r_pat [sspe_pkg::PATTERN_COUNT];
    logic [sspe_pkg::PATTERN_COUNT-1:0]       r_pat_vld;
    sspe_pkg::t_pattern                       r_undo;
    logic                                     r_undo_vld;

    sspe_pkg::t_pattern rd_pat;
    sspe_pkg::t_pattern undo_q;
    sspe_pkg::t_pattern n_pat;
    logic               wr_pat;
    logic               wr_undo;

    // never-written entries read as cleared
    assign rd_pat = r_pat_vld[i_req.sel] ? r_pat[i_req.sel] : '0;
    assign undo_q = r_undo_vld ? r_undo : '0;

    always_comb begin
        o_triggers = '0;
        for (int t = 0; t < sspe_pkg::TRIG_TRACKS; t++) begin
            o_triggers[t] = i_req.tick & rd_pat[t][i_req.pos];
        end
    end

    always_comb begin
        n_pat = rd_pat;
        if (i_req.toggle) begin
            n_pat[i_req.trk][i_req.stp] = ~rd_pat[i_req.trk][i_req.stp];
        end else if (i_req.clear) begin
            n_pat = '0;
        end else if (i_req.undo) begin
            n_pat = undo_q;
        end
    end

    assign wr_pat  = i_req.toggle | i_req.clear | i_req.undo;
    assign wr_undo = i_req.clear | i_req.undo;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pat_vld  <= '0;
            r_undo_vld <= 1'b0;
        end else begin
            if (wr_pat) begin
                r_pat_vld[i_req.sel] <= 1'b1;
            end
            if (wr_undo) begin
                r_undo_vld <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_pat) begin
            r_pat[i_req.sel] <= n_pat;
        end
        if (wr_undo) begin
            r_undo <= rd_pat;
        end
    end

endmodule

[rtl/sspe_sequencer.sv]
// Transport, view, playlist and configuration state with per-beat command decode.
module sspe_sequencer (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_fire,
    input  sspe_pkg::t_in_item    i_item,
    input  sspe_pkg::t_cfg_wr     i_cfg,
    output sspe_pkg::t_store_req  o_req,
    output sspe_pkg::t_status     o_status
);

    localparam int CW = sspe_pkg::CMP_W;

    logic                                  r_mode;
    logic [sspe_pkg::LEN_W-1:0]            r_song_len;
    logic                                  r_run;
    logic [sspe_pkg::STEP_IW-1:0]          r_pos;
    logic [sspe_pkg::SLOT_IW-1:0]          r_cur;
    logic [sspe_pkg::PAT_IW-1:0]           r_view;
    logic [sspe_pkg::FIELD_W-1:0]          r_cur_entry;   // shadow of playlist at cursor
    logic [sspe_pkg::FIELD_W-1:0]          r_list [sspe_pkg::SONG_SLOTS];

    logic                                  n_run;
    logic [sspe_pkg::STEP_IW-1:0]          n_pos;
    logic [sspe_pkg::SLOT_IW-1:0]          n_cur;
    logic [sspe_pkg::PAT_IW-1:0]           n_view;
    logic [sspe_pkg::FIELD_W-1:0]          n_entry;

    logic [CW-1:0] eff_len;
    logic [CW-1:0] play_id;
    logic [CW-1:0] post_id;
    logic [CW-1:0] pos_x;
    logic [CW-1:0] view_x;
    logic [CW-1:0] step_x;
    logic [CW-1:0] slot_x;
    logic [CW-1:0] post_pos_x;
    logic [CW-1:0] post_view_x;
    logic [sspe_pkg::SLOT_IW-1:0] slot_idx;
    logic          play_ok;
    logic          wrap;
    logic          tick;
    logic          toggle;
    logic          clear;
    logic          undo;
    logic          list_we;

    assign pos_x    = CW'(r_pos);
    assign view_x   = CW'(r_view);
    assign step_x   = CW'(i_item.step);
    assign slot_x   = CW'(i_item.slot);
    assign slot_idx = slot_x[sspe_pkg::SLOT_IW-1:0];

    // song length 0 plays as 1, above the slot count as the slot count
    always_comb begin
        if (r_song_len == '0) begin
            eff_len = CW'(1);
        end else if (CW'(r_song_len) > CW'(sspe_pkg::SONG_SLOTS)) begin
            eff_len = CW'(sspe_pkg::SONG_SLOTS);
        end else begin
            eff_len = CW'(r_song_len);
        end
    end

    assign play_id = r_mode ? CW'(r_cur_entry) : view_x;
    assign play_ok = play_id < CW'(sspe_pkg::PATTERN_COUNT);

    always_comb begin
        n_run   = r_run;
        n_pos   = r_pos;
        n_cur   = r_cur;
        n_view  = r_view;
        wrap    = 1'b0;
        tick    = 1'b0;
        toggle  = 1'b0;
        clear   = 1'b0;
        undo    = 1'b0;
        list_we = 1'b0;
        if (i_fire) begin
            case (i_item.func)
                sspe_pkg::FN_TICK: begin
                    if (r_run) begin
                        tick = 1'b1;
                        if (pos_x + CW'(1) >= CW'(sspe_pkg::STEP_COUNT)) begin
                            n_pos = '0;
                            wrap  = 1'b1;
                            if (r_mode) begin
                                if (CW'(r_cur) + CW'(1) >= eff_len) begin
                                    n_cur = '0;
                                end else begin
                                    n_cur = r_cur + 1'b1;
                                end
                            end
                        end else begin
                            n_pos = r_pos + 1'b1;
                        end
                    end
                end
                sspe_pkg::FN_PLAY: begin
                    n_run = 1'b1;
                end
                sspe_pkg::FN_STOP: begin
                    n_run = 1'b0;
                    n_pos = '0;
                    n_cur = '0;
                end
                sspe_pkg::FN_NEXT: begin
                    if (view_x + CW'(1) < CW'(sspe_pkg::PATTERN_COUNT)) begin
                        n_view = r_view + 1'b1;
                    end
                end
                sspe_pkg::FN_PREV: begin
                    if (r_view != '0) begin
                        n_view = r_view - 1'b1;
                    end
                end
                sspe_pkg::FN_TOGGLE: begin
                    toggle = (CW'(i_item.track) < CW'(sspe_pkg::TRACK_COUNT))
                           && (step_x < CW'(sspe_pkg::STEP_COUNT));
                end
                sspe_pkg::FN_CLEAR: begin
                    clear = 1'b1;
                end
                sspe_pkg::FN_UNDO: begin
                    undo = 1'b1;
                end
                sspe_pkg::FN_LIST: begin
                    list_we = slot_x < CW'(sspe_pkg::SONG_SLOTS);
                end
                default: begin
                end
            endcase
        end
    end

    // playlist entry at the new cursor, with this beat's write forwarded
    assign n_entry = (list_we && slot_idx == n_cur) ? i_item.slot_pattern : r_list[n_cur];

    always_comb begin
        o_req.tick   = tick & play_ok;
        o_req.toggle = toggle;
        o_req.clear  = clear;
        o_req.undo   = undo;
        o_req.sel    = tick ? play_id[sspe_pkg::PAT_IW-1:0] : r_view;
        o_req.trk    = i_item.track[sspe_pkg::TRK_IW-1:0];
        o_req.stp    = step_x[sspe_pkg::STEP_IW-1:0];
        o_req.pos    = r_pos;
    end

    assign post_id     = r_mode ? CW'(n_entry) : CW'(n_view);
    assign post_pos_x  = CW'(n_pos);
    assign post_view_x = CW'(n_view);

    always_comb begin
        o_status.wrapped         = wrap;
        o_status.position        = post_pos_x[sspe_pkg::FIELD_W-1:0];
        o_status.playing_pattern = post_id[sspe_pkg::FIELD_W-1:0];
        o_status.view_pattern    = post_view_x[sspe_pkg::FIELD_W-1:0];
        o_status.running         = n_run;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode      <= 1'b0;
            r_song_len  <= sspe_pkg::LEN_W'(1);
            r_run       <= 1'b0;
            r_pos       <= '0;
            r_cur       <= '0;
            r_view      <= '0;
            r_cur_entry <= '0;
            for (int i = 0; i < sspe_pkg::SONG_SLOTS; i++) begin
                r_list[i] <= '0;
            end
        end else begin
            if (i_cfg.we) begin
                case (i_cfg.index)
                    sspe_pkg::CFG_PLAY_MODE:   r_mode     <= i_cfg.data[0];
                    sspe_pkg::CFG_SONG_LENGTH: r_song_len <= i_cfg.data;
                    default: begin
                    end
                endcase
            end
            r_run       <= n_run;
            r_pos       <= n_pos;
            r_cur       <= n_cur;
            r_view      <= n_view;
            r_cur_entry <= n_entry;
            if (list_we) begin
                r_list[slot_idx] <= i_item.slot_pattern;
            end
        end
    end

endmodule

[rtl/sspe_checker.sv]
// Port-level checker for the step sequencer pattern engine and its bind.
module sspe_checker (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          o_in_stall,
    input  logic                          o_out_valid,
    input  logic                          i_out_stall,
    input  sspe_pkg::t_out_item           o_out_data
);

    // result beat held while stalled
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_out_data))
        else $error("result beat dropped or changed under stall");

    // with the output register empty the engine never backs up its input
    a_no_stall_when_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_out_valid |-> !o_in_stall)
        else $error("input stalled with empty output");

    // a wrap always lands on step zero with transport running
    a_wrap_pos: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_data.wrapped |->
            o_out_data.position == '0 && o_out_data.running)
        else $error("wrap without position zero or transport");

    // triggers only come from a tick while playing
    a_trig_running: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_data.triggers != '0 |-> o_out_data.running)
        else $error("triggers while stopped");

endmodule

bind step_sequencer_pattern_engine sspe_checker u_sspe_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .o_in_stall  (o_in_stall),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .o_out_data  (o_out_data)
);
